// ===== rtl/core/ed_pkg.sv =====
`timescale 1ns / 1ps

package ed_pkg;

    localparam int SUM_W      = 42;
    localparam int DIST_W     = 21;
    localparam int DIM_W      = 11;
    localparam int ROOT_STEPS = DIST_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [SUM_W-1:0] ROOT_BIT0 = SUM_W'(1) << (SUM_W - 2);

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] root;
    } sqrt_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_ACC  = 5'b00100,
        ST_ROOT = 5'b01000,
        ST_EMIT = 5'b10000
    } ed_state_t;

endpackage

// ===== rtl/core/euclidean_distance.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Handshake              Payload
// config     in         psel/penable/pready    paddr, pwrite, pwdata, prdata
// input      in         in_valid/in_ready      coord_a, coord_b
// output     out        out_valid/out_ready    distance
//
// A pair that does not close a vector passes through capture, multiply and accumulate.
// A closing pair adds 21 square-root steps on the one compare/subtract unit,
// then the root is handed back and loaded into the output register.
// in_ready is low while a pair is in work; a stalled output holds the next result in the root unit.
// Reset clears the sum, the pair count and the output valid; the dimension register resets to 1.

module euclidean_distance
    import ed_pkg::*;
#(
    parameter int MAX_DIMENSIONS = 1024,
    parameter int COORD_WIDTH    = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] coord_a,
    input  logic signed [COORD_WIDTH-1:0] coord_b,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [DIST_W-1:0]             distance
);

    localparam int MAG_W = COORD_WIDTH + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int ACC_W = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
    localparam int CNT_W = $clog2(MAX_DIMENSIONS + 1);
    localparam int CMP_W = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;

    ed_state_t         state_reg, state_next;
    logic [DIM_W-1:0]  dim_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [DIST_W-1:0] distance_reg;
    logic              out_valid_reg, out_valid_next;

    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]        mag;
    logic [ACC_W-1:0]        acc_sum;
    logic [SUM_W-1:0]        sum_sat;
    logic [CMP_W-1:0]        eff_dims;
    logic                    last_pair;
    logic                    cfg_write;
    logic                    load_out;
    sqrt_req_t               sqrt_req;
    sqrt_rsp_t               sqrt_rsp;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {{(32 - DIM_W){1'b0}}, dim_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dim_reg <= DIM_W'(1);
        else if (cfg_write)
            dim_reg <= pwdata[DIM_W-1:0];
    end

    assign diff = MAG_W'(coord_a) - MAG_W'(coord_b);
    assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    assign acc_sum = ACC_W'(sum_reg) + ACC_W'(sq_reg);
    assign sum_sat = (acc_sum > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_W-1:0];

    always_comb
    begin
        eff_dims = CMP_W'(dim_reg);
        if (dim_reg == '0)
            eff_dims = CMP_W'(1);
        else if (eff_dims > CMP_W'(MAX_DIMENSIONS))
            eff_dims = CMP_W'(MAX_DIMENSIONS);
    end

    assign last_pair = (CMP_W'(count_reg) + CMP_W'(1)) >= eff_dims;
    assign in_ready  = (state_reg == ST_IDLE);
    assign load_out  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = sum_sat;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (last_pair)
                begin
                    sqrt_req.start = 1'b1;
                    sum_next       = '0;
                    count_next     = '0;
                    state_next     = ST_ROOT;
                end
                else
                begin
                    sum_next   = sum_sat;
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_rsp.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            mag_reg <= mag;
        if (state_reg == ST_MUL)
            sq_reg <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
        if (load_out)
            distance_reg <= sqrt_rsp.root;
    end

    ed_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

endmodule

// ===== rtl/core/ed_sqrt.sv =====
`timescale 1ns / 1ps

module ed_sqrt
    import ed_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  res_reg, res_next;
    logic [SUM_W-1:0]  bit_reg, bit_next;
    logic [SUM_W:0]    trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(ROOT_STEPS - 1);
            rem_next  = req.radicand;
            res_next  = '0;
            bit_next  = ROOT_BIT0;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[SUM_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[DIST_W-1:0];

endmodule
